FILE: rtl/nnc_pkg.sv
// Shared types, constants and helpers for the nearest-neighbor classifier.
`timescale 1ns / 1ps

package nnc_pkg;

    localparam int FEATURE_BITS   = 16;
    localparam int LABEL_BITS     = 16;
    localparam int DIST_BITS      = 38;
    localparam int ROW_FIELD_BITS = 8;
    localparam int COL_FIELD_BITS = 6;
    localparam int ROWS_CFG_BITS  = 9;
    localparam int COLS_CFG_BITS  = 7;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 1;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // input item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLS_IN_USE = 1'b1;

    // per-row issue control from the sequencer to the distance unit
    typedef struct packed {
        logic valid;   // row read issued this cycle
        logic live;    // accumulator entry holds data, else reads as zero
        logic add_en;  // column in range, add the squared difference
        logic track;   // last feature of the query, run the min search
    } nnc_issue_t;

    // index bits for an array of n entries, at least one
    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: rtl/nnc_feature_store.sv
// Training feature memory and label memory, registered reads.
`timescale 1ns / 1ps

module nnc_feature_store
    import nnc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [idx_bits(MAX_ROWS)-1:0]      wr_row,
    input  logic [idx_bits(MAX_COLS)-1:0]      wr_col,
    input  logic signed [FEATURE_BITS-1:0]     wr_value,
    input  logic [LABEL_BITS-1:0]              wr_label,
    input  logic                               rd_en,
    input  logic [idx_bits(MAX_ROWS)-1:0]      rd_row,
    input  logic [idx_bits(MAX_COLS)-1:0]      rd_col,
    output logic signed [FEATURE_BITS-1:0]     rd_value,
    input  logic                               lbl_rd_en,
    input  logic [idx_bits(MAX_ROWS)-1:0]      lbl_rd_row,
    output logic [LABEL_BITS-1:0]              lbl_rd_label
);

    localparam int COL_AW     = idx_bits(MAX_COLS);
    localparam int FEAT_DEPTH = MAX_ROWS * (1 << COL_AW);

    logic [FEATURE_BITS-1:0] feat_mem [FEAT_DEPTH];
    logic [LABEL_BITS-1:0]   label_mem [MAX_ROWS];

    logic [FEATURE_BITS-1:0] rd_value_reg;
    logic [LABEL_BITS-1:0]   lbl_rd_reg;

    // row-major, each row padded to a power of two columns
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            feat_mem[{wr_row, wr_col}] <= wr_value;
        end
        if (rd_en)
        begin
            rd_value_reg <= feat_mem[{rd_row, rd_col}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[wr_row] <= wr_label;
        end
        if (lbl_rd_en)
        begin
            lbl_rd_reg <= label_mem[lbl_rd_row];
        end
    end

    assign rd_value     = rd_value_reg;
    assign lbl_rd_label = lbl_rd_reg;

endmodule

FILE: rtl/nnc_dist_unit.sv
// Distance accumulator memory with read-add-write pipeline and min search.
`timescale 1ns / 1ps

module nnc_dist_unit
    import nnc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nnc_issue_t                        issue,
    input  logic [idx_bits(MAX_ROWS)-1:0]     issue_row,
    input  logic signed [FEATURE_BITS-1:0]    query_value,
    input  logic signed [FEATURE_BITS-1:0]    feat_value,
    output logic                              busy,
    output logic [idx_bits(MAX_ROWS)-1:0]     best_row,
    output logic [DIST_BITS-1:0]              best_dist
);

    localparam int ROW_AW  = idx_bits(MAX_ROWS);
    localparam int MAG_BITS = FEATURE_BITS + 1;
    localparam int SQ_BITS  = 2 * MAG_BITS;

    logic [DIST_BITS-1:0] acc_mem [MAX_ROWS];
    logic [DIST_BITS-1:0] acc_rd_reg;

    // stage control
    nnc_issue_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic       s4_valid_reg;
    logic       s4_track_reg;

    // stage payload
    logic [ROW_AW-1:0]    s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;
    logic [MAG_BITS-1:0]  s2_mag_reg;
    logic [DIST_BITS-1:0] s2_acc_reg, s3_acc_reg;
    logic [SQ_BITS-1:0]   s3_sq_reg;
    logic [DIST_BITS-1:0] s4_dist_reg;
    logic [ROW_AW-1:0]    best_row_reg;
    logic [DIST_BITS-1:0] best_dist_reg;

    logic signed [MAG_BITS-1:0] diff;
    logic [MAG_BITS-1:0]        mag;
    logic [SQ_BITS-1:0]         sq;
    logic [DIST_BITS:0]         sum;
    logic [DIST_BITS-1:0]       sum_sat;
    logic                       take_min;

    assign diff = {query_value[FEATURE_BITS-1], query_value}
                - {feat_value[FEATURE_BITS-1], feat_value};
    assign mag  = diff[MAG_BITS-1] ? (~diff + MAG_BITS'(1)) : diff;
    // |diff| < 2^16, so the square never reaches the saturation limit
    assign sq   = s2_mag_reg * s2_mag_reg;

    assign sum     = {1'b0, s3_acc_reg} + (DIST_BITS + 1)'(s3_sq_reg);
    assign sum_sat = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];

    // rows arrive in ascending order, so a strict compare keeps the lowest
    assign take_min = s4_valid_reg && s4_track_reg
                   && ((s4_row_reg == '0) || (s4_dist_reg < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            acc_rd_reg <= acc_mem[issue_row];
        end
        if (s3_ctl_reg.valid)
        begin
            acc_mem[s3_row_reg] <= sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg   <= '0;
            s2_ctl_reg   <= '0;
            s3_ctl_reg   <= '0;
            s4_valid_reg <= 1'b0;
            s4_track_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg   <= issue;
            s2_ctl_reg   <= s1_ctl_reg;
            s3_ctl_reg   <= s2_ctl_reg;
            s4_valid_reg <= s3_ctl_reg.valid;
            s4_track_reg <= s3_ctl_reg.track;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg  <= issue_row;
        s2_row_reg  <= s1_row_reg;
        s2_mag_reg  <= mag;
        s2_acc_reg  <= s1_ctl_reg.live ? acc_rd_reg : '0;
        s3_row_reg  <= s2_row_reg;
        s3_acc_reg  <= s2_acc_reg;
        s3_sq_reg   <= s2_ctl_reg.add_en ? sq : '0;
        s4_row_reg  <= s3_row_reg;
        s4_dist_reg <= sum_sat;
        if (take_min)
        begin
            best_row_reg  <= s4_row_reg;
            best_dist_reg <= s4_dist_reg;
        end
    end

    assign busy      = s1_ctl_reg.valid || s2_ctl_reg.valid || s3_ctl_reg.valid
                    || s4_valid_reg;
    assign best_row  = best_row_reg;
    assign best_dist = best_dist_reg;

`ifndef ASSERT_OFF
    // a row is never read in the cycle its write-back lands
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && s3_ctl_reg.valid) |-> (issue_row != s3_row_reg))
        else $error("accumulator read and write-back hit the same row");

    a_sq_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_ctl_reg.valid |-> (s3_sq_reg[SQ_BITS-1:2*FEATURE_BITS] == '0))
        else $error("squared difference out of range");

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_ctl_reg.valid |=> (s2_ctl_reg.valid && s4_valid_reg == $past(s3_ctl_reg.valid)))
        else $error("distance pipeline dropped a row");
`endif

endmodule

FILE: rtl/nearest_neighbor_classifier_top.sv
// Load item: written when accepted, no stall. Query feature: input stalls until it is done,
// one stored row per cycle through the accumulator memory, plus a 4-stage drain.
// The last feature adds a label read (none with no rows searched) before the result is
// registered; a new item is taken while that result waits.
// Reset clears control and configuration (rows_in_use = 0, cols_in_use = 1); no clearing
// pass: a fill count marks accumulator rows at or above it as zero.
`timescale 1ns / 1ps

module nearest_neighbor_classifier_top
    import nnc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [ROW_FIELD_BITS-1:0]      row,
    input  logic [COL_FIELD_BITS-1:0]      col,
    input  logic signed [FEATURE_BITS-1:0] value,
    input  logic [LABEL_BITS-1:0]          label,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [LABEL_BITS-1:0]          class_label,
    output logic                           found,
    output logic [DIST_BITS-1:0]           best_distance
);

    localparam int ROW_AW = idx_bits(MAX_ROWS);
    localparam int COL_AW = idx_bits(MAX_COLS);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_LABEL,
        ST_EMIT
    } state_t;

    state_t                     state_reg, state_next;
    logic [ROWS_CFG_BITS-1:0]   rows_in_use_reg, rows_in_use_next;
    logic [COLS_CFG_BITS-1:0]   cols_in_use_reg, cols_in_use_next;
    logic signed [FEATURE_BITS-1:0] value_reg, value_next;
    logic [COL_AW-1:0]          col_reg, col_next;
    logic                       last_reg, last_next;
    logic                       add_en_reg, add_en_next;
    logic [NR_W-1:0]            nrows_reg, nrows_next;
    logic [ROW_AW-1:0]          cnt_reg, cnt_next;
    logic [NR_W-1:0]            hw_reg, hw_next;
    logic                       out_valid_reg, out_valid_next;
    logic [LABEL_BITS-1:0]      class_label_reg, class_label_next;
    logic                       found_reg, found_next;
    logic [DIST_BITS-1:0]       best_distance_reg, best_distance_next;

    logic                       load_we;
    logic                       query_take;
    logic                       out_free;
    logic [NR_W-1:0]            nrows_eff;
    logic                       col_in_range;
    nnc_issue_t                 issue;
    logic signed [FEATURE_BITS-1:0] feat_value;
    logic [LABEL_BITS-1:0]      best_label;
    logic                       dist_busy;
    logic [ROW_AW-1:0]          best_row;
    logic [DIST_BITS-1:0]       best_dist;

    assign in_stall   = (state_reg != ST_IDLE);
    assign load_we    = in_valid && !in_stall && (kind == KIND_LOAD)
                     && (32'(row) < MAX_ROWS) && (32'(col) < MAX_COLS);
    assign query_take = in_valid && !in_stall && (kind == KIND_QUERY);
    assign out_free   = !out_valid_reg || !out_stall;

    assign nrows_eff    = (32'(rows_in_use_reg) > MAX_ROWS) ? NR_W'(MAX_ROWS)
                                                            : NR_W'(rows_in_use_reg);
    assign col_in_range = (32'(col) < 32'(cols_in_use_reg)) && (32'(col) < MAX_COLS);

    assign issue.valid  = (state_reg == ST_RUN);
    assign issue.live   = (NR_W'(cnt_reg) < hw_reg);
    assign issue.add_en = add_en_reg;
    assign issue.track  = last_reg;

    nnc_feature_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_store (
        .clk          (clk),
        .wr_en        (load_we),
        .wr_row       (ROW_AW'(row)),
        .wr_col       (COL_AW'(col)),
        .wr_value     (value),
        .wr_label     (label),
        .rd_en        (issue.valid),
        .rd_row       (cnt_reg),
        .rd_col       (col_reg),
        .rd_value     (feat_value),
        .lbl_rd_en    (state_reg == ST_LABEL),
        .lbl_rd_row   (best_row),
        .lbl_rd_label (best_label)
    );

    nnc_dist_unit #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .issue_row   (cnt_reg),
        .query_value (value_reg),
        .feat_value  (feat_value),
        .busy        (dist_busy),
        .best_row    (best_row),
        .best_dist   (best_dist)
    );

    always_comb
    begin
        state_next         = state_reg;
        rows_in_use_next   = rows_in_use_reg;
        cols_in_use_next   = cols_in_use_reg;
        value_next         = value_reg;
        col_next           = col_reg;
        last_next          = last_reg;
        add_en_next        = add_en_reg;
        nrows_next         = nrows_reg;
        cnt_next           = cnt_reg;
        hw_next            = hw_reg;
        out_valid_next     = out_valid_reg && out_stall;
        class_label_next   = class_label_reg;
        found_next         = found_reg;
        best_distance_next = best_distance_reg;

        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_in_use_next = cfg_data[ROWS_CFG_BITS-1:0];
                REG_COLS_IN_USE: cols_in_use_next = cfg_data[COLS_CFG_BITS-1:0];
                default:         rows_in_use_next = rows_in_use_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (query_take)
                begin
                    value_next  = value;
                    col_next    = COL_AW'(col);
                    last_next   = last;
                    add_en_next = col_in_range;
                    nrows_next  = nrows_eff;
                    cnt_next    = '0;
                    state_next  = (nrows_eff != '0) ? ST_RUN : ST_DRAIN;
                end
            end
            ST_RUN:
            begin
                if (NR_W'(cnt_reg) == nrows_reg - NR_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + ROW_AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    if (last_reg)
                    begin
                        // query done: every accumulator reads as zero again
                        hw_next    = '0;
                        state_next = (nrows_reg != '0) ? ST_LABEL : ST_EMIT;
                    end
                    else
                    begin
                        if (nrows_reg > hw_reg)
                        begin
                            hw_next = nrows_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LABEL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    found_next         = (nrows_reg != '0);
                    class_label_next   = (nrows_reg != '0) ? best_label : '0;
                    best_distance_next = (nrows_reg != '0) ? best_dist : '0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rows_in_use_reg   <= '0;
            cols_in_use_reg   <= COLS_CFG_BITS'(1);
            value_reg         <= '0;
            col_reg           <= '0;
            last_reg          <= 1'b0;
            add_en_reg        <= 1'b0;
            nrows_reg         <= '0;
            cnt_reg           <= '0;
            hw_reg            <= '0;
            out_valid_reg     <= 1'b0;
            class_label_reg   <= '0;
            found_reg         <= 1'b0;
            best_distance_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            rows_in_use_reg   <= rows_in_use_next;
            cols_in_use_reg   <= cols_in_use_next;
            value_reg         <= value_next;
            col_reg           <= col_next;
            last_reg          <= last_next;
            add_en_reg        <= add_en_next;
            nrows_reg         <= nrows_next;
            cnt_reg           <= cnt_next;
            hw_reg            <= hw_next;
            out_valid_reg     <= out_valid_next;
            class_label_reg   <= class_label_next;
            found_reg         <= found_next;
            best_distance_reg <= best_distance_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign class_label   = class_label_reg;
    assign found         = found_reg;
    assign best_distance = best_distance_reg;

`ifndef ASSERT_OFF
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (NR_W'(cnt_reg) < nrows_reg))
        else $error("row counter beyond searched rows");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(hw_reg) <= MAX_ROWS))
        else $error("accumulator fill count beyond memory depth");

    a_label_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LABEL) |-> (last_reg && (nrows_reg != '0) && !dist_busy))
        else $error("label lookup without a finished search");

    a_result_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(out_valid_reg) && out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

FILE: verif/nearest_neighbor_classifier_top_test.sv
// Self-checking testbench for the nearest-neighbor classifier against a predicted nearest row.
`timescale 1ns / 1ps

module nearest_neighbor_classifier_top_test;
    import nnc_pkg::*;

    localparam int TABLE_ROWS     = DEF_MAX_ROWS;
    localparam int TABLE_COLS     = DEF_MAX_COLS;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 8;

    typedef struct {
        logic                           kind;
        logic [ROW_FIELD_BITS-1:0]      row;
        logic [COL_FIELD_BITS-1:0]      col;
        logic signed [FEATURE_BITS-1:0] value;
        logic [LABEL_BITS-1:0]          label;
        logic                           last;
    } nn_request_t;

    typedef struct {
        logic [LABEL_BITS-1:0] class_label;
        logic                  found;
        logic [DIST_BITS-1:0]  best_distance;
    } nn_answer_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [CFG_INDEX_BITS-1:0]      cfg_index;
    logic [CFG_DATA_BITS-1:0]       cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           kind;
    logic [ROW_FIELD_BITS-1:0]      row;
    logic [COL_FIELD_BITS-1:0]      col;
    logic signed [FEATURE_BITS-1:0] value;
    logic [LABEL_BITS-1:0]          label;
    logic                           last;
    logic                           out_valid;
    logic                           out_stall;
    logic [LABEL_BITS-1:0]          class_label;
    logic                           found;
    logic [DIST_BITS-1:0]           best_distance;

    // predictor state
    logic signed [FEATURE_BITS-1:0] feat_mem [TABLE_ROWS][TABLE_COLS];
    logic [LABEL_BITS-1:0]          label_mem [TABLE_ROWS];
    logic [DIST_BITS-1:0]           row_distance [TABLE_ROWS];
    logic [ROWS_CFG_BITS-1:0]       cfg_rows;
    logic [COLS_CFG_BITS-1:0]       cfg_cols;

    nn_answer_t  nearest_expected [$];
    nn_request_t pending [$];
    bit          loaded [TABLE_ROWS][TABLE_COLS];

    logic in_taken;
    int   send_gap;
    int   send_calm;
    int   hold_left;
    int   recv_calm;
    int   mismatches;
    int   idle_cycles;

    nearest_neighbor_classifier_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .row           (row),
        .col           (col),
        .value         (value),
        .label         (label),
        .last          (last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .class_label   (class_label),
        .found         (found),
        .best_distance (best_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void predict_nearest(input nn_request_t req);
        int     searched;
        int     best;
        longint diff;
        longint sum;
        nn_answer_t ans;
        searched = (cfg_rows > TABLE_ROWS) ? TABLE_ROWS : int'(cfg_rows);
        if (req.kind == KIND_LOAD)
        begin
            feat_mem[req.row][req.col] = req.value;
            label_mem[req.row] = req.label;
            return;
        end
        if (req.col < cfg_cols)
        begin
            for (int r = 0; r < searched; r++)
            begin
                diff = longint'(req.value) - longint'(feat_mem[r][req.col]);
                sum  = longint'(row_distance[r]) + diff * diff;
                if (sum > longint'(DIST_MAX))
                    sum = longint'(DIST_MAX);
                row_distance[r] = sum[DIST_BITS-1:0];
            end
        end
        if (!req.last)
            return;
        if (searched == 0)
        begin
            ans.class_label   = '0;
            ans.found         = 1'b0;
            ans.best_distance = '0;
        end
        else
        begin
            best = 0;
            for (int r = 1; r < searched; r++)
                if (row_distance[r] < row_distance[best])
                    best = r;
            ans.class_label   = label_mem[best];
            ans.found         = 1'b1;
            ans.best_distance = row_distance[best];
        end
        nearest_expected.push_back(ans);
        for (int r = 0; r < TABLE_ROWS; r++)
            row_distance[r] = '0;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        nn_request_t req;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                req = pending.pop_front();
                kind  <= req.kind;
                row   <= req.row;
                col   <= req.col;
                value <= req.value;
                label <= req.label;
                last  <= req.last;
                in_valid <= 1'b1;
                send_gap = pick_gap(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        int g;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            g = pick_gap(recv_calm);
            hold_left = (g > 0) ? g - 1 : 0;
            out_stall <= (g > 0);
        end
    end

    // monitor: check results, then predict from the request taken at this edge
    always @(posedge clk)
    begin
        nn_answer_t  want;
        nn_request_t req;
        in_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall)
        begin
            if (nearest_expected.size() == 0)
            begin
                $error("unexpected result: class_label %0h found %0b best_distance %0d",
                       class_label, found, best_distance);
                mismatches++;
            end
            else
            begin
                want = nearest_expected.pop_front();
                if (class_label !== want.class_label)
                begin
                    $error("class_label: expected %0h, got %0h", want.class_label, class_label);
                    mismatches++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, found);
                    mismatches++;
                end
                if (best_distance !== want.best_distance)
                begin
                    $error("best_distance: expected %0d, got %0d",
                           want.best_distance, best_distance);
                    mismatches++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            req.kind  = kind;
            req.row   = row;
            req.col   = col;
            req.value = value;
            req.label = label;
            req.last  = last;
            predict_nearest(req);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic signed [FEATURE_BITS-1:0] rand_feature(input bit coarse);
        logic signed [FEATURE_BITS-1:0] v;
        if (coarse)
        begin
            case ($urandom_range(0, 2))
                0:       v = -16'sd256;
                1:       v = 16'sd0;
                default: v = 16'sd256;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       v = 16'sh8000;
                1:       v = 16'sh7fff;
                default: v = FEATURE_BITS'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic queue_load(input int r, input int c, input logic signed [15:0] v,
                              input int lab, input bit lst);
        nn_request_t req;
        req.kind  = KIND_LOAD;
        req.row   = r[ROW_FIELD_BITS-1:0];
        req.col   = c[COL_FIELD_BITS-1:0];
        req.value = v;
        req.label = lab[LABEL_BITS-1:0];
        req.last  = lst;
        pending.push_back(req);
        loaded[r][c] = 1'b1;
    endtask

    // row and label are don't-care on a query, so they carry noise
    task automatic queue_query(input int c, input logic signed [15:0] v, input bit lst);
        nn_request_t req;
        req.kind  = KIND_QUERY;
        req.row   = ROW_FIELD_BITS'($urandom);
        req.col   = c[COL_FIELD_BITS-1:0];
        req.value = v;
        req.label = LABEL_BITS'($urandom);
        req.last  = lst;
        pending.push_back(req);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data[CFG_DATA_BITS-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (idx == REG_ROWS_IN_USE)
            cfg_rows = data[ROWS_CFG_BITS-1:0];
        else
            cfg_cols = data[COLS_CFG_BITS-1:0];
    endtask

    // all requests taken, all results back, then room for a query with no result to finish
    task automatic wait_quiet();
        while (pending.size() != 0 || in_valid || nearest_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int rows, input int cols, input int budget,
                             input bit coarse, input bit extreme);
        int searched;
        int active;
        int made;
        int n;
        int j;
        int t;
        int pick;
        int order [TABLE_COLS];
        searched = (rows > TABLE_ROWS) ? TABLE_ROWS : rows;
        active   = (cols > TABLE_COLS) ? TABLE_COLS : cols;
        wait_quiet();
        write_reg(REG_ROWS_IN_USE, rows);
        write_reg(REG_COLS_IN_USE, cols);
        // every entry a query can read gets written first; small sets are rewritten
        for (int r = 0; r < searched; r++)
            for (int c = 0; c < active; c++)
                if (!loaded[r][c] || searched * active <= 8 || extreme)
                    queue_load(r, c, extreme ? 16'sh8000 : rand_feature(coarse),
                               $urandom_range(0, 65535), 1'b0);
        if (extreme)
            for (int c = 0; c < active; c++)
                queue_query(c, 16'sh7fff, c == active - 1);
        made = 0;
        while (made < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                for (int i = 0; i < active; i++)
                    order[i] = i;
                for (int i = active - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (int i = 0; i < active; i++)
                    queue_query(order[i], rand_feature(coarse), i == active - 1);
                made += active;
            end
            else if (pick < 78)
            begin
                queue_load($urandom_range(0, TABLE_ROWS - 1), $urandom_range(0, TABLE_COLS - 1),
                           rand_feature(coarse), $urandom_range(0, 65535),
                           1'($urandom_range(0, 1)));
                made++;
            end
            else if (pick < 92)
            begin
                // broken vector: a few features, any of them maybe out of range, maybe no last
                n = $urandom_range(1, (active < 4) ? active : 4);
                for (int i = 0; i < n; i++)
                begin
                    if (cols < TABLE_COLS && $urandom_range(0, 3) == 0)
                        t = $urandom_range(cols, TABLE_COLS - 1);
                    else
                        t = $urandom_range(0, active - 1);
                    queue_query(t, rand_feature(coarse),
                                (i == n - 1) && $urandom_range(0, 1));
                end
                made += n;
            end
            else
            begin
                if (cols < TABLE_COLS)
                    queue_query($urandom_range(cols, TABLE_COLS - 1), rand_feature(coarse), 1'b1);
                else
                    queue_query($urandom_range(0, active - 1), rand_feature(coarse), 1'b1);
                made++;
            end
        end
    endtask

    initial
    begin
        int ph_rows [NUM_PHASES]  = '{400, 1, 9, 0, 12, 2, 1, 4};
        int ph_cols [NUM_PHASES]  = '{1, 40, 3, 5, 2, 8, 1, 4};
        int ph_budget [NUM_PHASES] = '{10, 0, 15, 8, 15, 12, 8, 15};
        bit ph_coarse [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 1};
        bit ph_extreme [NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 0, 0};
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_LOAD;
        row          = '0;
        col          = '0;
        value        = '0;
        label        = '0;
        last         = 1'b0;
        out_stall    = 1'b0;
        in_taken     = 1'b0;
        send_gap     = 0;
        send_calm    = 0;
        hold_left    = 0;
        recv_calm    = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        cfg_rows     = '0;
        cfg_cols     = 7'd1;
        for (int r = 0; r < TABLE_ROWS; r++)
        begin
            row_distance[r] = '0;
            label_mem[r]    = '0;
            for (int c = 0; c < TABLE_COLS; c++)
                feat_mem[r][c] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no rows searched, last on a load, column past cols_in_use
        queue_query(0, 16'sh7fff, 1'b1);
        queue_load(TABLE_ROWS - 1, TABLE_COLS - 1, 16'sh8000, 'hffff, 1'b1);
        queue_query(TABLE_COLS - 1, 16'sh8000, 1'b0);
        queue_query(0, 16'sh0000, 1'b1);
        wait_quiet();

        // four rows, rows 1 and 2 equal: the lower one must win the tie
        write_reg(REG_ROWS_IN_USE, 4);
        write_reg(REG_COLS_IN_USE, 3);
        for (int c = 0; c < 3; c++)
        begin
            queue_load(0, c, 16'sd1000, 'h11, 1'b0);
            queue_load(1, c, 16'sd0, 'h22, 1'b0);
            queue_load(2, c, 16'sd0, 'h33, 1'b0);
            queue_load(3, c, 16'sh7fff, 'h44, 1'b0);
        end
        queue_query(2, 16'sd0, 1'b0);
        queue_query(0, 16'sd0, 1'b0);
        queue_query(1, 16'sd0, 1'b1);
        // nothing added at all: every row ties at zero
        queue_query(40, 16'sd0, 1'b1);
        queue_query(1, 16'sh7fff, 1'b0);
        queue_query(0, 16'sh8000, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(ph_rows[p], ph_cols[p], ph_budget[p], ph_coarse[p], ph_extreme[p]);

        // column count above the vector width: every column is in range
        wait_quiet();
        write_reg(REG_ROWS_IN_USE, 1);
        write_reg(REG_COLS_IN_USE, 100);
        queue_load(0, TABLE_COLS - 1, rand_feature(1'b0), $urandom_range(0, 65535), 1'b0);
        queue_query(TABLE_COLS - 1, rand_feature(1'b0), 1'b0);
        queue_query(0, rand_feature(1'b0), 1'b1);

        wait_quiet();
        if (mismatches == 0 && nearest_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/nnc_pkg.sv
rtl/nnc_feature_store.sv
rtl/nnc_dist_unit.sv
rtl/nearest_neighbor_classifier_top.sv
verif/nearest_neighbor_classifier_top_test.sv
